@@ sv/tbgc_pkg.sv @@
// tbgc_pkg: shared types, codes and constants of the two-button gesture classifier.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tbgc_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int RESQ_DEPTH     = 4;

    localparam logic [CFG_W-1:0] LONG_PRESS_RESET   = 16'd500;
    localparam logic [CFG_W-1:0] CLICK_WINDOW_RESET = 16'd300;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_WINDOW = 1'b1;

    // input codes
    localparam logic       CMD_TICK    = 1'b0;
    localparam logic       CMD_KEY     = 1'b1;
    localparam logic [1:0] KEY_RELEASE = 2'd0;
    localparam logic [1:0] KEY_PRESS   = 2'd1;
    localparam logic [1:0] KEY_REPEAT  = 2'd2;

    // gesture codes
    localparam logic [1:0] KIND_SINGLE = 2'd0;
    localparam logic [1:0] KIND_DOUBLE = 2'd1;
    localparam logic [1:0] KIND_LONG   = 2'd2;
    localparam logic [1:0] KIND_DUAL   = 2'd3;

    typedef struct packed {
        logic       cmd;
        logic       button_id;
        logic [1:0] key_value;
    } in_word_t;

    typedef struct packed {
        logic       gesture_button;
        logic [1:0] gesture_kind;
        logic       last_result;
    } out_word_t;

    // results produced by one item, slot 0 first
    typedef struct packed {
        logic [1:0]           count;
        out_word_t [1:0]      res;
    } push_t;

endpackage

`default_nettype wire

@@ sv/tbgc_engine.sv @@
// tbgc_engine: per-button timers, click counters and dual-press latch; classifies one
// word per cycle while fire is high into up to two gestures. Depends on tbgc_pkg.
`default_nettype none

module tbgc_engine #(
    parameter int TIMER_BITS = tbgc_pkg::TIMER_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fire,
    input  tbgc_pkg::in_word_t              word,
    input  logic [tbgc_pkg::CFG_W-1:0]      long_press_ticks,
    input  logic [tbgc_pkg::CFG_W-1:0]      click_window_ticks,
    output tbgc_pkg::push_t                 push
);

    localparam int CMP_W = (TIMER_BITS > tbgc_pkg::CFG_W) ? TIMER_BITS : tbgc_pkg::CFG_W;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;

    logic [1:0][TIMER_BITS-1:0] hold_timer_reg,   hold_timer_next;
    logic [1:0][TIMER_BITS-1:0] window_timer_reg, window_timer_next;
    logic [1:0][1:0]            click_count_reg,  click_count_next;
    logic [1:0]                 hold_active_reg,  hold_active_next;
    logic [1:0]                 held_flag_reg,    held_flag_next;
    logic [1:0]                 window_open_reg,  window_open_next;
    logic                       dual_latch_reg,   dual_latch_next;

    always_comb
    begin
        logic [TIMER_BITS-1:0] wt_inc;
        logic                  expire;
        logic                  is_long;
        logic                  b;

        hold_timer_next   = hold_timer_reg;
        window_timer_next = window_timer_reg;
        click_count_next  = click_count_reg;
        hold_active_next  = hold_active_reg;
        held_flag_next    = held_flag_reg;
        window_open_next  = window_open_reg;
        dual_latch_next   = dual_latch_reg;
        push              = '0;
        wt_inc            = '0;
        expire            = 1'b0;
        is_long           = 1'b0;
        b                 = word.button_id;

        if (fire)
        begin
            if (word.cmd == tbgc_pkg::CMD_TICK)
            begin
                // button 0 reports ahead of button 1
                for (int i = 0; i < 2; i++)
                begin
                    if (hold_active_reg[i] && hold_timer_reg[i] != TMAX)
                    begin
                        hold_timer_next[i] = hold_timer_reg[i] + 1'b1;
                    end
                    if (window_open_reg[i])
                    begin
                        wt_inc = (window_timer_reg[i] != TMAX) ?
                                 window_timer_reg[i] + 1'b1 : window_timer_reg[i];
                        window_timer_next[i] = wt_inc;
                        expire = (CMP_W'(wt_inc) >= CMP_W'(click_window_ticks)) ||
                                 (wt_inc == TMAX);
                        if (expire)
                        begin
                            push.res[push.count[0]].gesture_button = 1'(i);
                            push.res[push.count[0]].gesture_kind =
                                (click_count_reg[i] >= 2'd2) ? tbgc_pkg::KIND_DOUBLE
                                                              : tbgc_pkg::KIND_SINGLE;
                            push.count           = push.count + 2'd1;
                            window_open_next[i]  = 1'b0;
                            window_timer_next[i] = '0;
                            click_count_next[i]  = 2'd0;
                        end
                    end
                end
            end
            else
            begin
                case (word.key_value)
                    tbgc_pkg::KEY_PRESS:
                    begin
                        hold_active_next[b] = 1'b1;
                        hold_timer_next[b]  = '0;
                        held_flag_next[b]   = 1'b1;
                    end
                    tbgc_pkg::KEY_RELEASE:
                    begin
                        if (!hold_active_reg[b])
                        begin
                            held_flag_next[b] = 1'b0;
                        end
                        else
                        begin
                            hold_active_next[b] = 1'b0;
                            hold_timer_next[b]  = '0;
                            is_long = (CMP_W'(hold_timer_reg[b]) > CMP_W'(long_press_ticks)) ||
                                      (hold_timer_reg[b] == TMAX);
                            if (!is_long)
                            begin
                                if (!window_open_reg[b])
                                begin
                                    window_open_next[b]  = 1'b1;
                                    window_timer_next[b] = '0;
                                    click_count_next[b]  = 2'd1;
                                end
                                else if (click_count_reg[b] != 2'd3)
                                begin
                                    click_count_next[b] = click_count_reg[b] + 2'd1;
                                end
                                held_flag_next[b] = 1'b0;
                            end
                            else if (dual_latch_reg)
                            begin
                                // swallow the second long release of a dual press
                                dual_latch_next = 1'b0;
                                held_flag_next  = 2'b00;
                            end
                            else if (held_flag_reg[0] && held_flag_reg[1])
                            begin
                                dual_latch_next             = 1'b1;
                                push.count                  = 2'd1;
                                push.res[0].gesture_button  = b;
                                push.res[0].gesture_kind    = tbgc_pkg::KIND_DUAL;
                            end
                            else
                            begin
                                push.count                  = 2'd1;
                                push.res[0].gesture_button  = b;
                                push.res[0].gesture_kind    = tbgc_pkg::KIND_LONG;
                                held_flag_next[b]           = 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                        // autorepeat and the unused code both mark the key as held
                        held_flag_next[b] = 1'b1;
                    end
                endcase
            end

            if (push.count == 2'd1)
            begin
                push.res[0].last_result = 1'b1;
            end
            else if (push.count == 2'd2)
            begin
                push.res[1].last_result = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_timer_reg   <= '0;
            window_timer_reg <= '0;
            click_count_reg  <= '0;
            hold_active_reg  <= '0;
            held_flag_reg    <= '0;
            window_open_reg  <= '0;
            dual_latch_reg   <= 1'b0;
        end
        else
        begin
            hold_timer_reg   <= hold_timer_next;
            window_timer_reg <= window_timer_next;
            click_count_reg  <= click_count_next;
            hold_active_reg  <= hold_active_next;
            held_flag_reg    <= held_flag_next;
            window_open_reg  <= window_open_next;
            dual_latch_reg   <= dual_latch_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/tbgc_result_q.sv @@
// tbgc_result_q: small result queue taking up to two gestures per cycle, one out per cycle while out_ready is high.
// Depends on tbgc_pkg.
`default_nettype none

module tbgc_result_q (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tbgc_pkg::push_t      push,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tbgc_pkg::out_word_t  out_data
);

    localparam int PTR_W = $clog2(tbgc_pkg::RESQ_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    tbgc_pkg::out_word_t mem_reg [tbgc_pkg::RESQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    // leave space for a tick that expires both windows
    assign room      = (count_reg <= CNT_W'(tbgc_pkg::RESQ_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.res[0];
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push.res[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push.count);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_reg + CNT_W'(push.count) - CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

@@ sv/two_button_gesture_classifier_core.sv @@
// Two-button gesture classifier: the accepted input word is registered, classified by
// the engine and written into the result queue, whose count drives result valid.
// Throughput is one word per cycle while each word yields at most one gesture and the
// output drains; a tick that closes both click windows gives two results, which leave
// one at a time through the single read port of the 4-entry result queue.
// Asynchronous active-low reset clears all timers, flags and the queue, and loads
// the long-press limit with 500 and the click window with 300.
`default_nettype none

module two_button_gesture_classifier_core #(
    parameter int TIMER_BITS = tbgc_pkg::TIMER_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  tbgc_pkg::in_word_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output tbgc_pkg::out_word_t               out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tbgc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tbgc_pkg::CFG_W-1:0]        cfg_data
);

    logic                        in_valid_reg;
    tbgc_pkg::in_word_t          in_word_reg;
    logic [tbgc_pkg::CFG_W-1:0]  long_press_reg;
    logic [tbgc_pkg::CFG_W-1:0]  click_window_reg;
    logic                        room;
    logic                        advance;
    tbgc_pkg::push_t             push;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && room;
    assign in_ready  = !in_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg   <= tbgc_pkg::LONG_PRESS_RESET;
            click_window_reg <= tbgc_pkg::CLICK_WINDOW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tbgc_pkg::CFG_LONG_PRESS:   long_press_reg   <= cfg_data;
                tbgc_pkg::CFG_CLICK_WINDOW: click_window_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_word_reg <= in_data;
        end
    end

    tbgc_engine #(
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .clk                (clk),
        .rst_n              (rst_n),
        .fire               (advance),
        .word               (in_word_reg),
        .long_press_ticks   (long_press_reg),
        .click_window_ticks (click_window_reg),
        .push               (push)
    );

    tbgc_result_q u_result_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

@@ sv/tbgc_checker.sv @@
// tbgc_checker: port-level checks of the gesture classifier, bound to the top level.
// Depends on tbgc_pkg and two_button_gesture_classifier_core.
`default_nettype none

module tbgc_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input tbgc_pkg::out_word_t  out_data
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // releases give one gesture, so long and dual press always close their word
    a_long_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.gesture_kind == tbgc_pkg::KIND_LONG ||
                      out_data.gesture_kind == tbgc_pkg::KIND_DUAL)
        |-> out_data.last_result)
        else $error("long press not marked as last result");

    // only a tick closing both windows gives two gestures, button 0 first
    a_first_of_two: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last_result
        |-> !out_data.gesture_button &&
            (out_data.gesture_kind == tbgc_pkg::KIND_SINGLE ||
             out_data.gesture_kind == tbgc_pkg::KIND_DOUBLE))
        else $error("bad first result of a pair");

    // the second gesture of a pair is already queued
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_result |=> out_valid)
        else $error("second result of a pair missing");

endmodule

bind two_button_gesture_classifier_core tbgc_checker u_tbgc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
